// ===== rtl/core/cau_pkg.sv =====
// cau_pkg: opcodes and fixed widths shared by the complex arithmetic unit
// no dependencies
package cau_pkg;
    localparam int OP_W = 3;
    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_CONJ = 3'd4
    } t_op;
endpackage

// ===== rtl/core/cau_div_cell.sv =====
// cau_div_cell: one restoring divide step on two magnitudes sharing one divisor
// depends on cau_pkg
module cau_div_cell
    import cau_pkg::*;
#(
    parameter int NW = 34,
    parameter int QW = 17,
    parameter int MW = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [NW-1:0] i_den,
    input  logic [NW-1:0] i_rem_re,
    input  logic [NW-1:0] i_rem_im,
    input  logic [QW-1:0] i_q_re,
    input  logic [QW-1:0] i_q_im,
    input  logic          i_bit_re,
    input  logic          i_bit_im,
    input  logic [MW-1:0] i_meta,
    input  logic          i_en,
    output logic          o_vld,
    output logic [NW-1:0] o_den,
    output logic [NW-1:0] o_rem_re,
    output logic [NW-1:0] o_rem_im,
    output logic [QW-1:0] o_q_re,
    output logic [QW-1:0] o_q_im,
    output logic [MW-1:0] o_meta
);
    localparam logic [QW:0] CAP = (QW+1)'(1) << (QW-1);
    logic [NW:0] s_re, s_im;
    logic        b_re, b_im;
    logic [QW:0] qn_re, qn_im;

    always_comb begin
        s_re  = {i_rem_re, i_bit_re};
        s_im  = {i_rem_im, i_bit_im};
        b_re  = s_re >= {1'b0, i_den};
        b_im  = s_im >= {1'b0, i_den};
        if (b_re) s_re = s_re - {1'b0, i_den};
        if (b_im) s_im = s_im - {1'b0, i_den};
        qn_re = {i_q_re, b_re};
        qn_im = {i_q_im, b_im};
        if (qn_re > CAP) qn_re = CAP;
        if (qn_im > CAP) qn_im = CAP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
        if (i_en) begin
            o_den    <= i_den;
            o_rem_re <= s_re[NW-1:0];
            o_rem_im <= s_im[NW-1:0];
            o_q_re   <= qn_re[QW-1:0];
            o_q_im   <= qn_im[QW-1:0];
            o_meta   <= i_meta;
        end
    end
endmodule

// ===== rtl/core/complex_arith_unit.sv =====
// complex_arith_unit: pipelined complex alu, add/sub/mul/div/conjugate
// depends on cau_pkg and cau_div_cell
//
// One item is accepted per clock while the output is not stalled, and each
// passes through 2*DATA_WIDTH + FRAC_BITS + 4 register stages, 44 at the
// default widths (the divide chain sets the figure; every opcode goes through
// it so order is kept). The stages are: products, sums to sign and magnitude,
// then a row of divide cells, each yielding one quotient bit for the real and
// imaginary parts at once (one cell per bit of the 2*DATA_WIDTH+1 bit
// dividend plus one per fraction bit), then saturation into an output
// register. The whole chain advances whenever the output register is empty or
// being taken, so back-pressure stalls it as one.
// Divide truncates toward zero; multiply drops FRAC_BITS fraction bits toward
// zero; all results saturate and raise overflow. b = 0 on a divide gives a
// zero result with div_zero set.
module complex_arith_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // op, a_re, a_im, b_re, b_im from bit 0 up, zero filled
    input  logic [((OP_W+4*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // res_re, res_im, overflow, div_zero from bit 0 up, zero filled
    output logic [((2*DATA_WIDTH+2+7)/8)*8-1:0] m_axis_tdata
);
    localparam int DW  = DATA_WIDTH;
    localparam int PW  = 2*DW+1;          // sum of two products, magnitude
    localparam int NW  = PW+1;            // remainder width
    localparam int QW  = DW+1;            // quotient up to cap 2^DW
    localparam int NC  = PW+FRAC_BITS;    // divide cells
    localparam int MW  = 2*PW+5+OP_W;     // meta carried with the chain
    localparam int OW  = ((2*DW+2+7)/8)*8;

    logic en;
    logic r_ovld;
    assign en            = !r_ovld || m_axis_tready;
    assign s_axis_tready = en;

    // field unpack
    logic [OP_W-1:0]      in_op;
    logic signed [DW-1:0] ar, ai, br, bi;
    assign in_op = s_axis_tdata[OP_W-1:0];
    assign ar    = s_axis_tdata[OP_W+DW-1:OP_W];
    assign ai    = s_axis_tdata[OP_W+2*DW-1:OP_W+DW];
    assign br    = s_axis_tdata[OP_W+3*DW-1:OP_W+2*DW];
    assign bi    = s_axis_tdata[OP_W+4*DW-1:OP_W+3*DW];

    // stage 1: products and plain sums
    logic                   r1_v;
    logic [OP_W-1:0]        r1_op;
    logic signed [2*DW-1:0] r1_pac, r1_pbd, r1_pad, r1_pbc, r1_pcc, r1_pdd;
    logic signed [DW:0]     r1_s_re, r1_s_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= s_axis_tvalid;
        end
        if (en) begin
            r1_op  <= in_op;
            r1_pac <= ar * br;
            r1_pbd <= ai * bi;
            r1_pad <= ar * bi;
            r1_pbc <= ai * br;
            r1_pcc <= br * br;
            r1_pdd <= bi * bi;
            case (t_op'(in_op))
                OP_ADD:  begin r1_s_re <= ar + br; r1_s_im <= ai + bi; end
                OP_SUB:  begin r1_s_re <= ar - br; r1_s_im <= ai - bi; end
                OP_CONJ: begin r1_s_re <= (DW+1)'(ar); r1_s_im <= -(DW+1)'(ai); end
                default: begin r1_s_re <= '0; r1_s_im <= '0; end
            endcase
        end
    end

    // stage 2: sums of products to sign and magnitude
    logic signed [PW:0] x_re, x_im, x_den;
    always_comb begin
        case (t_op'(r1_op))
            OP_MUL: begin
                x_re = (PW+1)'(r1_pac) - (PW+1)'(r1_pbd);
                x_im = (PW+1)'(r1_pad) + (PW+1)'(r1_pbc);
            end
            OP_DIV: begin
                x_re = (PW+1)'(r1_pac) + (PW+1)'(r1_pbd);
                x_im = (PW+1)'(r1_pbc) - (PW+1)'(r1_pad);
            end
            default: begin
                x_re = (PW+1)'(r1_s_re);
                x_im = (PW+1)'(r1_s_im);
            end
        endcase
        x_den = (PW+1)'(r1_pcc) + (PW+1)'(r1_pdd);
    end

    logic          r2_v, r2_nre, r2_nim;
    logic [OP_W-1:0] r2_op;
    logic [PW-1:0] r2_mre, r2_mim, r2_den;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
        if (en) begin
            r2_op  <= r1_op;
            r2_nre <= x_re[PW];
            r2_nim <= x_im[PW];
            r2_mre <= x_re[PW] ? PW'(-x_re) : x_re[PW-1:0];
            r2_mim <= x_im[PW] ? PW'(-x_im) : x_im[PW-1:0];
            r2_den <= x_den[PW-1:0];
        end
    end

    // dividend bit of cell g, msb first
    function automatic logic r2_chain_bit(input logic [MW-1:0] m, input logic re,
                                          input int g);
        logic [PW-1:0] v;
        v = re ? m[2*PW:PW+1] : m[PW:1];
        return v[PW-1-g];
    endfunction

    // divide chain; meta = {op, nre, nim, 2'b00, mre, mim, dz}
    logic          c_v   [NC+1];
    logic [NW-1:0] c_den [NC+1];
    logic [NW-1:0] c_rre [NC+1];
    logic [NW-1:0] c_rim [NC+1];
    logic [QW-1:0] c_qre [NC+1];
    logic [QW-1:0] c_qim [NC+1];
    logic [MW-1:0] c_meta[NC+1];
    logic          dz2;
    assign dz2 = (t_op'(r2_op) == OP_DIV) && (r2_den == '0);

    assign c_v[0]    = r2_v;
    assign c_den[0]  = (r2_den == '0) ? NW'(1) : NW'(r2_den);
    assign c_rre[0]  = '0;
    assign c_rim[0]  = '0;
    assign c_qre[0]  = '0;
    assign c_qim[0]  = '0;
    assign c_meta[0] = {r2_op, r2_nre, r2_nim, 2'b00, r2_mre, r2_mim, dz2};

    for (genvar g = 0; g < NC; g++) begin : g_cell
        logic b_re, b_im;
        assign b_re = (g < PW) ? r2_chain_bit(c_meta[g], 1'b1, g) : 1'b0;
        assign b_im = (g < PW) ? r2_chain_bit(c_meta[g], 1'b0, g) : 1'b0;
        cau_div_cell #(.NW(NW), .QW(QW), .MW(MW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (c_v[g]),
            .i_den   (c_den[g]),
            .i_rem_re(c_rre[g]),
            .i_rem_im(c_rim[g]),
            .i_q_re  (c_qre[g]),
            .i_q_im  (c_qim[g]),
            .i_bit_re(b_re),
            .i_bit_im(b_im),
            .i_meta  (c_meta[g]),
            .i_en    (en),
            .o_vld   (c_v[g+1]),
            .o_den   (c_den[g+1]),
            .o_rem_re(c_rre[g+1]),
            .o_rem_im(c_rim[g+1]),
            .o_q_re  (c_qre[g+1]),
            .o_q_im  (c_qim[g+1]),
            .o_meta  (c_meta[g+1])
        );
    end

    // output stage: pick magnitude, saturate
    logic [MW-1:0]   fm;
    logic [OP_W-1:0] f_op;
    logic            f_nre, f_nim, f_dz, f_ovf;
    logic [PW-1:0]   f_mre, f_mim, s_mre, s_mim;
    logic [DW-1:0]   f_ore, f_oim;

    function automatic logic [DW:0] sat(input logic neg, input logic [PW-1:0] mag);
        logic [DW-1:0] lim;
        lim = {1'b1, {(DW-1){1'b0}}};
        if (!neg) begin
            if (mag > PW'(lim) - PW'(1)) return {1'b1, lim - DW'(1)};
            return {1'b0, mag[DW-1:0]};
        end
        if (mag > PW'(lim)) return {1'b1, lim};
        return {1'b0, DW'(-mag[DW-1:0])};
    endfunction

    logic [DW:0] sre, sim;
    always_comb begin
        fm    = c_meta[NC];
        f_dz  = fm[0];
        f_mim = fm[PW:1];
        f_mre = fm[2*PW:PW+1];
        f_nim = fm[2*PW+3];
        f_nre = fm[2*PW+4];
        f_op  = fm[MW-1:MW-OP_W];
        case (t_op'(f_op))
            OP_MUL: begin
                s_mre = f_mre >> FRAC_BITS;
                s_mim = f_mim >> FRAC_BITS;
            end
            OP_DIV: begin
                s_mre = f_dz ? '0 : PW'(c_qre[NC]);
                s_mim = f_dz ? '0 : PW'(c_qim[NC]);
            end
            OP_ADD, OP_SUB, OP_CONJ: begin
                s_mre = f_mre;
                s_mim = f_mim;
            end
            default: begin
                s_mre = '0;
                s_mim = '0;
            end
        endcase
        sre   = sat(f_nre && s_mre != '0, s_mre);
        sim   = sat(f_nim && s_mim != '0, s_mim);
        f_ore = sre[DW-1:0];
        f_oim = sim[DW-1:0];
        f_ovf = sre[DW] | sim[DW];
    end

    logic [DW-1:0] r_ore, r_oim;
    logic          r_ovf, r_dz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= c_v[NC];
        end
        if (en) begin
            r_ore <= f_ore;
            r_oim <= f_oim;
            r_ovf <= f_ovf;
            r_dz  <= f_dz;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = OW'({r_dz, r_ovf, r_oim, r_ore});

    // div_zero only ever accompanies a zero result without overflow
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_dz) |-> (r_ore == '0 && r_oim == '0 && !r_ovf))
        else $error("div_zero item with nonzero result");
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !m_axis_tready) |=> (r_ovld && $stable(m_axis_tdata)))
        else $error("stalled result changed");
    // ready is high whenever the output register is empty
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ovld |-> s_axis_tready)
        else $error("input stalled with empty output");
endmodule

// ===== dv/tb_complex_arith_unit.sv =====
// tb_complex_arith_unit: self-checking bench for the complex arithmetic unit
// depends on cau_pkg and complex_arith_unit; predicts each result itself and
// compares it with what the stream output delivers, under several idling phases
module tb_complex_arith_unit;
    import cau_pkg::*;

    localparam int DW = 16;
    localparam int FB = 8;
    localparam int IN_W = ((OP_W + 4*DW + 7)/8)*8;
    localparam int OUT_W = ((2*DW + 2 + 7)/8)*8;
    localparam int LATENCY = 2*DW + FB + 4;

    typedef struct packed {
        logic [DW-1:0] b_im;
        logic [DW-1:0] b_re;
        logic [DW-1:0] a_im;
        logic [DW-1:0] a_re;
        logic [OP_W-1:0] op;
    } t_operands;

    typedef struct packed {
        logic          div_zero;
        logic          overflow;
        logic [DW-1:0] res_im;
        logic [DW-1:0] res_re;
    } t_cplx_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // op, a_re, a_im, b_re, b_im from bit 0 up, zero filled
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // res_re, res_im, overflow, div_zero from bit 0 up, zero filled
    logic [OUT_W-1:0] m_axis_tdata;

    complex_arith_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_operands pending_items[$];
    t_cplx_res expected_results[$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        n_errors = 0;
    int        n_checked = 0;
    int        n_sent = 0;
    int        n_ovf = 0;
    int        n_dz = 0;

    // saturate a signed wide value into DW bits, flagging any clamp
    function automatic logic [DW-1:0] clamp(input longint v, inout logic ovf);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (DW-1)) - 1;
        lo = -(64'sd1 <<< (DW-1));
        if (v > hi) begin
            ovf = 1'b1;
            return hi[DW-1:0];
        end
        if (v < lo) begin
            ovf = 1'b1;
            return lo[DW-1:0];
        end
        return v[DW-1:0];
    endfunction

    // quotient magnitude with FB fraction bits, truncated, capped at 2^DW
    function automatic longint frac_quot(input longint num, input longint den);
        longint cap;
        longint q;
        longint r;
        cap = 64'sd1 <<< DW;
        q = num / den;
        r = num % den;
        if (q > cap) q = cap;
        for (int i = 0; i < FB; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 1;
            end
            if (q > cap) q = cap;
        end
        return q;
    endfunction

    // truncate toward zero: shift the magnitude, keep the sign
    function automatic longint trunc_shift(input longint v);
        return (v < 0) ? -((-v) >>> FB) : (v >>> FB);
    endfunction

    function automatic longint sgn_quot(input longint num, input longint den);
        return (num < 0) ? -frac_quot(-num, den) : frac_quot(num, den);
    endfunction

    function automatic t_cplx_res predict_cplx(input t_operands it);
        t_cplx_res r;
        longint ar, ai, br, bi, re, im, den;
        ar = longint'($signed(it.a_re));
        ai = longint'($signed(it.a_im));
        br = longint'($signed(it.b_re));
        bi = longint'($signed(it.b_im));
        re = 0;
        im = 0;
        r = '0;
        case (it.op)
            OP_ADD: begin re = ar + br; im = ai + bi; end
            OP_SUB: begin re = ar - br; im = ai - bi; end
            OP_MUL: begin
                re = trunc_shift(ar*br - ai*bi);
                im = trunc_shift(ar*bi + ai*br);
            end
            OP_DIV: begin
                den = br*br + bi*bi;
                if (den == 0) begin
                    r.div_zero = 1'b1;
                end else begin
                    re = sgn_quot(ar*br + ai*bi, den);
                    im = sgn_quot(ai*br - ar*bi, den);
                end
            end
            OP_CONJ: begin re = ar; im = -ai; end
            default: ;
        endcase
        r.res_re = clamp(re, r.overflow);
        r.res_im = clamp(im, r.overflow);
        return r;
    endfunction

    // driver: valid held until taken, next item loaded in the same step
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= IN_W'(pending_items.pop_front());
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // predict on acceptance, so expectations follow input order
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_results.push_back(predict_cplx(t_operands'(s_axis_tdata[OP_W+4*DW-1:0])));
            n_sent++;
        end
    end

    // monitor with random back-pressure
    always @(posedge i_clk) begin
        t_cplx_res got;
        t_cplx_res want;
        if (i_rst_n) begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_cplx_res'(m_axis_tdata[2*DW+1:0]);
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    n_checked++;
                    if (want.overflow) n_ovf++;
                    if (want.div_zero) n_dz++;
                    if (got !== want) begin
                        $display("%0t: mismatch expected re=%h im=%h ovf=%b dz=%b, actual re=%h im=%h ovf=%b dz=%b",
                                 $time, want.res_re, want.res_im, want.overflow, want.div_zero,
                                 got.res_re, got.res_im, got.overflow, got.div_zero);
                        n_errors++;
                    end
                end
            end
        end
    end

    function automatic t_operands mk(input t_op op, input int ar, input int ai,
                                     input int br, input int bi);
        t_operands it;
        it.op = op;
        it.a_re = ar[DW-1:0];
        it.a_im = ai[DW-1:0];
        it.b_re = br[DW-1:0];
        it.b_im = bi[DW-1:0];
        return it;
    endfunction

    // mostly small operands so divides and products stay in range, some full-scale
    function automatic logic [DW-1:0] rand_part();
        case ($urandom_range(5))
            0: return DW'($urandom);
            1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            2: return 16'h0000;
            default: return DW'($signed($urandom_range(2047)) - 1024);
        endcase
    endfunction

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
        t_operands it;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) begin
            it.op = ($urandom_range(19) == 0) ? OP_W'($urandom_range(7, 5))
                                              : OP_W'($urandom_range(4));
            it.a_re = rand_part();
            it.a_im = rand_part();
            it.b_re = rand_part();
            it.b_im = rand_part();
            if (it.op == OP_DIV && $urandom_range(9) == 0) begin
                it.b_re = '0;
                it.b_im = '0;
            end
            pending_items.push_back(it);
        end
        wait (pending_items.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
    endtask

    initial begin
        // directed: extremes, every operation, zero divisor, unused codes, conj clamp
        pending_items.push_back(mk(OP_ADD, 32767, 32767, 1, 1));
        pending_items.push_back(mk(OP_ADD, -32768, -32768, -1, -1));
        pending_items.push_back(mk(OP_SUB, -32768, 32767, 1, -1));
        pending_items.push_back(mk(OP_SUB, 256, -256, 512, 512));
        pending_items.push_back(mk(OP_MUL, 256, 0, 256, 0));
        pending_items.push_back(mk(OP_MUL, -32768, -32768, -32768, -32768));
        pending_items.push_back(mk(OP_MUL, -1, 1, 1, 1));
        pending_items.push_back(mk(OP_MUL, 32767, -32768, 32767, 32767));
        pending_items.push_back(mk(OP_DIV, 512, 256, 256, 0));
        pending_items.push_back(mk(OP_DIV, 300, -700, 0, 0));
        pending_items.push_back(mk(OP_DIV, 32767, 32767, 1, 0));
        pending_items.push_back(mk(OP_DIV, -32768, 5, 0, -1));
        pending_items.push_back(mk(OP_DIV, -7, 3, 1000, -2000));
        pending_items.push_back(mk(OP_DIV, -32768, -32768, -32768, -32768));
        pending_items.push_back(mk(OP_CONJ, 1234, -32768, 0, 0));
        pending_items.push_back(mk(OP_CONJ, -32768, 32767, 99, 99));
        pending_items.push_back(mk(t_op'(3'd5), 100, 100, 100, 100));
        pending_items.push_back(mk(t_op'(3'd6), -1, -1, -1, -1));
        pending_items.push_back(mk(t_op'(3'd7), 32767, -32768, 1, 2));
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_phase(0, 0, 0);
        run_phase(0, 0, 140);
        run_phase(55, 0, 140);
        run_phase(0, 55, 140);
        run_phase(14, 14, 130);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("checked %0d results from %0d items over four idling phases", n_checked, n_sent);
        $display("saturated results %0d, zero-divisor results %0d", n_ovf, n_dz);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
